@@ hdl/lrc_pkg.sv @@
// lrc parser package: shared types, codes and character constants
`default_nettype none
package lrc_pkg;

    // result kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    localparam logic [13:0] ACC_MAX = 14'd9999;
    localparam int unsigned MIN_MS  = 60000;
    localparam int unsigned SEC_MS  = 1000;

    localparam int unsigned TS_W = 30;

    // line parse position
    typedef enum logic [2:0] {
        MODE_LEAD    = 3'd0,
        MODE_NEWLINE = 3'd1,
        MODE_MIN     = 3'd2,
        MODE_SEC     = 3'd3,
        MODE_FRAC    = 3'd4,
        MODE_TEXT    = 3'd5,
        MODE_SKIP    = 3'd6
    } t_mode;

    // sequencer state
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_TS_MIN  = 3'd1,
        ST_TS_SEC  = 3'd2,
        ST_TS_FRAC = 3'd3,
        ST_START   = 3'd4,
        ST_BLANK   = 3'd5,
        ST_CHAR    = 3'd6,
        ST_END     = 3'd7
    } t_state;

    // class of the incoming byte
    typedef enum logic [3:0] {
        CLS_ZERO   = 4'd0,
        CLS_DIGIT  = 4'd1,
        CLS_BLANK  = 4'd2,
        CLS_LF     = 4'd3,
        CLS_CR     = 4'd4,
        CLS_LBRACK = 4'd5,
        CLS_RBRACK = 4'd6,
        CLS_COLON  = 4'd7,
        CLS_DOT    = 4'd8,
        CLS_OTHER  = 4'd9
    } t_cls;

    // timestamp build steps
    typedef enum logic [1:0] {
        TS_NONE = 2'd0,
        TS_MIN  = 2'd1,
        TS_SEC  = 2'd2,
        TS_FRAC = 2'd3
    } t_ts_step;

    // which result goes into the output register
    typedef enum logic [1:0] {
        SRC_START = 2'd0,
        SRC_BLANK = 2'd1,
        SRC_CHAR  = 2'd2,
        SRC_END   = 2'd3
    } t_src;

    typedef struct packed {
        logic     capture;
        logic     acc_clear;
        logic     acc_min;
        logic     acc_sec;
        logic     acc_frac;
        t_ts_step ts_step;
        logic     blank_push;
        logic     line_clear;
        logic     count_clear;
        logic     drain_start;
        logic     drain_next;
        logic     emit;
        t_src     emit_src;
        logic     emit_last;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic frac_full;
        logic count_zero;
        logic drain_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ hdl/lrc_dp.sv @@
// lrc parser datapath: accumulators, timestamp build, blank buffer, output register
`default_nettype none
module lrc_dp
    import lrc_pkg::*;
#(
    parameter int MAX_BLANK_RUN = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [7:0]      i_text_byte_in,
    input  wire t_cmd            i_cmd,
    output t_sts                 o_sts,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_kind,
    output logic [TS_W-1:0]      o_timestamp_ms,
    output logic [7:0]           o_text_byte_out,
    output logic                 o_blank_overflow,
    output logic                 o_last_of_run
);

    localparam int CNT_W  = $clog2(MAX_BLANK_RUN + 1);
    localparam int ADDR_W = (MAX_BLANK_RUN > 1) ? $clog2(MAX_BLANK_RUN) : 1;

    logic [13:0]       r_min;
    logic [13:0]       r_sec;
    logic [9:0]        r_frac;
    logic [1:0]        r_frac_digits;
    logic [TS_W-1:0]   r_ts;
    logic [7:0]        r_byte;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic              r_ovf;
    logic              r_blank_mem [MAX_BLANK_RUN];
    logic              r_rd_data;

    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [TS_W-1:0]   r_out_ts;
    logic [7:0]        r_out_byte;
    logic              r_out_ovf;
    logic              r_out_last;

    logic [3:0]        digit;
    logic [13:0]       n_min_acc;
    logic [13:0]       n_sec_acc;
    logic [16:0]       min_x10;
    logic [16:0]       sec_x10;
    logic [TS_W-1:0]   frac_scaled;
    logic              out_free;
    t_cls              cls;

    // byte classification
    always_comb begin
        priority if (i_text_byte_in == CH_NUL) begin
            cls = CLS_ZERO;
        end else if (i_text_byte_in >= CH_ZERO && i_text_byte_in <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else if (i_text_byte_in == CH_SPACE || i_text_byte_in == CH_TAB) begin
            cls = CLS_BLANK;
        end else if (i_text_byte_in == CH_LF) begin
            cls = CLS_LF;
        end else if (i_text_byte_in == CH_CR) begin
            cls = CLS_CR;
        end else if (i_text_byte_in == CH_LBRACK) begin
            cls = CLS_LBRACK;
        end else if (i_text_byte_in == CH_RBRACK) begin
            cls = CLS_RBRACK;
        end else if (i_text_byte_in == CH_COLON) begin
            cls = CLS_COLON;
        end else if (i_text_byte_in == CH_DOT) begin
            cls = CLS_DOT;
        end else begin
            cls = CLS_OTHER;
        end
    end

    assign digit = i_text_byte_in[3:0];

    // acc * 10 + digit as shift-add, then clamp
    assign min_x10 = {r_min, 3'b000} + {2'b00, r_min, 1'b0} + {13'd0, digit};
    assign sec_x10 = {r_sec, 3'b000} + {2'b00, r_sec, 1'b0} + {13'd0, digit};
    assign n_min_acc = (min_x10 > {3'b000, ACC_MAX}) ? ACC_MAX : min_x10[13:0];
    assign n_sec_acc = (sec_x10 > {3'b000, ACC_MAX}) ? ACC_MAX : sec_x10[13:0];

    // fraction scaled to three digits
    always_comb begin
        unique case (r_frac_digits)
            2'd0:    frac_scaled = '0;
            2'd1:    frac_scaled = TS_W'(r_frac) * TS_W'(100);
            2'd2:    frac_scaled = TS_W'(r_frac) * TS_W'(10);
            default: frac_scaled = TS_W'(r_frac);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            r_min         <= '0;
            r_sec         <= '0;
            r_frac        <= '0;
            r_frac_digits <= '0;
        end else begin
            if (i_cmd.acc_min) begin
                r_min <= n_min_acc;
            end
            if (i_cmd.acc_sec) begin
                r_sec <= n_sec_acc;
            end
            if (i_cmd.acc_frac) begin
                r_frac        <= 10'(({r_frac, 3'b000} + {r_frac, 1'b0}) + {9'd0, digit});
                r_frac_digits <= r_frac_digits + 2'd1;
            end
        end
        unique case (i_cmd.ts_step)
            TS_MIN:  r_ts <= TS_W'(r_min) * TS_W'(MIN_MS);
            TS_SEC:  r_ts <= r_ts + TS_W'(r_sec) * TS_W'(SEC_MS);
            TS_FRAC: r_ts <= r_ts + frac_scaled;
            default: r_ts <= r_ts;
        endcase
        if (i_cmd.capture) begin
            r_byte <= i_text_byte_in;
        end
    end

    // blank run buffer
    always_comb begin
        priority if (i_cmd.drain_start) begin
            n_idx = '0;
        end else if (i_cmd.drain_next) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blank_push && r_count < CNT_W'(MAX_BLANK_RUN)) begin
            r_blank_mem[r_count[ADDR_W-1:0]] <= (i_text_byte_in == CH_TAB);
        end
        r_rd_data <= r_blank_mem[n_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.line_clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.count_clear) begin
                r_count <= '0;
            end else if (i_cmd.blank_push) begin
                if (r_count < CNT_W'(MAX_BLANK_RUN)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_last <= i_cmd.emit_last;
            r_out_ts   <= '0;
            r_out_byte <= '0;
            r_out_ovf  <= 1'b0;
            unique case (i_cmd.emit_src)
                SRC_START: begin
                    r_kind   <= KIND_START;
                    r_out_ts <= r_ts;
                end
                SRC_BLANK: begin
                    r_kind     <= KIND_TEXT;
                    r_out_byte <= r_rd_data ? CH_TAB : CH_SPACE;
                end
                SRC_CHAR: begin
                    r_kind     <= KIND_TEXT;
                    r_out_byte <= r_byte;
                end
                default: begin
                    r_kind    <= KIND_END;
                    r_out_ovf <= r_ovf;
                end
            endcase
        end
    end

    assign o_sts.cls        = cls;
    assign o_sts.frac_full  = (r_frac_digits == 2'd3);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.drain_last = (CNT_W'(r_idx + 1'b1) == r_count);
    assign o_sts.out_free   = out_free;

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_timestamp_ms   = r_out_ts;
    assign o_text_byte_out  = r_out_byte;
    assign o_blank_overflow = r_out_ovf;
    assign o_last_of_run    = r_out_last;

endmodule
`default_nettype wire

@@ hdl/lrc_ctrl.sv @@
// lrc parser controller: line parse mode and result sequencing
`default_nettype none
module lrc_ctrl
    import lrc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    t_mode  r_mode;
    t_mode  n_mode;
    logic   r_line_started;
    logic   n_line_started;
    logic   r_end_zero;
    logic   n_end_zero;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mode         <= MODE_LEAD;
            r_line_started <= 1'b0;
            r_end_zero     <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_mode         <= n_mode;
            r_line_started <= n_line_started;
            r_end_zero     <= n_end_zero;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_line_started = r_line_started;
        n_end_zero     = r_end_zero;
        o_cmd          = '0;
        o_cmd.ts_step  = TS_NONE;
        o_cmd.emit_src = SRC_CHAR;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.cls == CLS_ZERO) begin
                        n_mode = MODE_LEAD;
                        if (r_mode == MODE_TEXT && r_line_started) begin
                            n_end_zero = 1'b1;
                            n_state    = ST_END;
                        end else begin
                            n_line_started   = 1'b0;
                            o_cmd.acc_clear  = 1'b1;
                            o_cmd.line_clear = 1'b1;
                        end
                    end else begin
                        unique case (r_mode)
                            MODE_LEAD, MODE_NEWLINE: begin
                                priority case (i_sts.cls)
                                    CLS_BLANK: n_mode = MODE_LEAD;
                                    CLS_LBRACK: begin
                                        o_cmd.acc_clear = 1'b1;
                                        n_mode          = MODE_MIN;
                                    end
                                    CLS_LF: n_mode = MODE_NEWLINE;
                                    CLS_CR: n_mode = (r_mode == MODE_NEWLINE) ?
                                                     MODE_NEWLINE : MODE_SKIP;
                                    default: n_mode = MODE_SKIP;
                                endcase
                            end
                            MODE_MIN: begin
                                priority case (i_sts.cls)
                                    CLS_DIGIT: o_cmd.acc_min = 1'b1;
                                    CLS_COLON: n_mode = MODE_SEC;
                                    CLS_LF:    n_mode = MODE_NEWLINE;
                                    default:   n_mode = MODE_SKIP;
                                endcase
                            end
                            MODE_SEC: begin
                                priority case (i_sts.cls)
                                    CLS_DIGIT: o_cmd.acc_sec = 1'b1;
                                    CLS_DOT, CLS_COLON: n_mode = MODE_FRAC;
                                    CLS_RBRACK: begin
                                        n_mode  = MODE_TEXT;
                                        n_state = ST_TS_MIN;
                                    end
                                    CLS_LF:  n_mode = MODE_NEWLINE;
                                    default: n_mode = MODE_SKIP;
                                endcase
                            end
                            MODE_FRAC: begin
                                priority if (i_sts.cls == CLS_DIGIT && !i_sts.frac_full) begin
                                    o_cmd.acc_frac = 1'b1;
                                end else if (i_sts.cls == CLS_RBRACK) begin
                                    n_mode  = MODE_TEXT;
                                    n_state = ST_TS_MIN;
                                end else if (i_sts.cls == CLS_LF) begin
                                    n_mode = MODE_NEWLINE;
                                end else begin
                                    n_mode = MODE_SKIP;
                                end
                            end
                            MODE_TEXT: begin
                                priority if (i_sts.cls == CLS_LF || i_sts.cls == CLS_CR) begin
                                    n_mode = MODE_NEWLINE;
                                    if (r_line_started) begin
                                        n_end_zero = 1'b0;
                                        n_state    = ST_END;
                                    end else begin
                                        o_cmd.line_clear = 1'b1;
                                    end
                                end else if (i_sts.cls == CLS_BLANK) begin
                                    o_cmd.blank_push = 1'b1;
                                end else if (!r_line_started) begin
                                    n_state = ST_START;
                                end else if (!i_sts.count_zero) begin
                                    o_cmd.drain_start = 1'b1;
                                    n_state           = ST_BLANK;
                                end else begin
                                    n_state = ST_CHAR;
                                end
                            end
                            default: begin
                                n_mode = (i_sts.cls == CLS_LF) ? MODE_NEWLINE : MODE_SKIP;
                            end
                        endcase
                    end
                end
            end
            ST_TS_MIN: begin
                o_cmd.ts_step = TS_MIN;
                n_state       = ST_TS_SEC;
            end
            ST_TS_SEC: begin
                o_cmd.ts_step = TS_SEC;
                n_state       = ST_TS_FRAC;
            end
            ST_TS_FRAC: begin
                o_cmd.ts_step    = TS_FRAC;
                o_cmd.line_clear = 1'b1;
                n_line_started   = 1'b0;
                n_state          = ST_IDLE;
            end
            ST_START: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = SRC_START;
                    n_line_started = 1'b1;
                    if (i_sts.count_zero) begin
                        n_state = ST_CHAR;
                    end else begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = ST_BLANK;
                    end
                end
            end
            ST_BLANK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_src   = SRC_BLANK;
                    o_cmd.drain_next = 1'b1;
                    if (i_sts.drain_last) begin
                        o_cmd.count_clear = 1'b1;
                        n_state           = ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_src  = SRC_CHAR;
                    o_cmd.emit_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                // line end, and full clear when the text ended
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_src   = SRC_END;
                    o_cmd.emit_last  = 1'b1;
                    o_cmd.line_clear = 1'b1;
                    o_cmd.acc_clear  = r_end_zero;
                    n_line_started   = 1'b0;
                    n_state          = ST_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/lrc_lyric_line_parser.sv @@
// lrc lyric line parser top level
`default_nettype none
// Parses lyric text, one byte per input transaction, into line-start
// (timestamp in ms), text-byte and line-end results on a valid/ready output
// channel with a registered result stage. Most bytes are taken one per cycle.
// A closing bracket of a timestamp holds the input after the accept for the
// three steps of the timestamp build (minutes, seconds, fraction terms added
// one per cycle). A byte that produces results holds the input while they
// are emitted one at a time as the output side takes them (line start, each
// buffered blank read from the blank-run memory, then the byte itself); a
// line end holds it until its result is emitted. Blank runs longer than
// MAX_BLANK_RUN are truncated and the line end carries the overflow flag.
module lrc_lyric_line_parser
    import lrc_pkg::*;
#(
    parameter int MAX_BLANK_RUN = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_text_byte_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [1:0]           o_kind,
    output logic [TS_W-1:0]      o_timestamp_ms,
    output logic [7:0]           o_text_byte_out,
    output logic                 o_blank_overflow,
    output logic                 o_last_of_run
);

    t_cmd cmd;
    t_sts sts;

    lrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lrc_dp #(
        .MAX_BLANK_RUN (MAX_BLANK_RUN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_byte_in   (i_text_byte_in),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_timestamp_ms   (o_timestamp_ms),
        .o_text_byte_out  (o_text_byte_out),
        .o_blank_overflow (o_blank_overflow),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
`default_nettype wire
